[rtl/cs_pkg.sv]
package cs_pkg;

    localparam int ELEM_W    = 16;
    localparam int DOT_W     = 42;
    localparam int NORM_W    = 41;
    localparam int MUL_W     = 42;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int Q_W       = 16;
    localparam int ROOT_W    = 116;
    localparam int LSH       = 30;
    localparam int STEP_W    = 6;
    localparam int MUL_STEPS = MUL_W;
    localparam int MAX_LEN_D = 2048;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_a;
        logic signed [ELEM_W-1:0] element_b;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] similarity;
        logic                     zero_norm;
        logic                     too_long;
    } t_out;

    typedef struct packed {
        logic accum;
        logic load_p;
        logic mul_step;
        logic save_p;
        logic save_l;
        logic root_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic root_last;
    } t_sts;

endpackage

[rtl/cosine_similarity_q15.sv]
// Streaming cosine similarity of two Q1.15 vectors. Element pairs are taken one per cycle
// while the input is not stalled, and accumulate into a saturating dot product and two
// squared norms. After the pair marked last the input stalls while the result is formed by
// two shift-add multiplies (the norm product, then the squared dot) and a 16-step
// square-root-and-divide search, all skipped when a norm is zero. The result is rounded
// toward zero and saturated; too_long flags vectors longer than MAX_LEN.
module cosine_similarity_q15 import cs_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_D
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    cs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cs_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in_data),
        .o_sts   (sts),
        .o_out   (o_out_data)
    );

endmodule

[rtl/cs_datapath.sv]
module cs_datapath import cs_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_D
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in,
    output t_sts o_sts,
    output t_out o_out
);

    localparam int CNT_W = $clog2(MAX_LEN + 2);

    logic signed [DOT_W-1:0]  r_dot;
    logic        [NORM_W-1:0] r_na, r_nb;
    logic        [CNT_W-1:0]  r_cnt;
    logic                     r_ovf;
    logic        [PROD_W-1:0] r_mc, r_prod, r_p, r_l;
    logic        [MUL_W-1:0]  r_mp;
    logic        [ROOT_W-1:0] r_s, r_ts, r_ps;
    logic        [Q_W-1:0]    r_q;
    logic        [3:0]        r_k;
    t_out                     r_out;

    logic signed [2*ELEM_W-1:0] ab;
    logic        [ELEM_W-1:0]   ua, ub;
    logic        [2*ELEM_W-1:0] ua2, ub2;
    logic signed [DOT_W:0]      dsum;
    logic        [NORM_W:0]     nsa, nsb;
    logic        [MUL_W-1:0]    mag;
    logic        [ROOT_W-1:0]   trial, lhs;
    logic        [CNT_W-1:0]    cnt_inc;
    logic        [Q_W:0]        qneg;

    always_comb begin
        ab   = i_in.element_a * i_in.element_b;
        ua   = i_in.element_a[ELEM_W-1] ? ELEM_W'(-i_in.element_a) : i_in.element_a;
        ub   = i_in.element_b[ELEM_W-1] ? ELEM_W'(-i_in.element_b) : i_in.element_b;
        ua2  = ua * ua;
        ub2  = ub * ub;
        dsum = (DOT_W+1)'(r_dot) + (DOT_W+1)'(ab);
        nsa  = {1'b0, r_na} + (NORM_W+1)'(ua2);
        nsb  = {1'b0, r_nb} + (NORM_W+1)'(ub2);
        mag  = r_dot[DOT_W-1] ? MUL_W'(-r_dot) : MUL_W'(r_dot);
        trial = r_s + r_ts + r_ps;
        lhs   = ROOT_W'({r_l, {LSH{1'b0}}});
        cnt_inc = (r_cnt <= CNT_W'(MAX_LEN)) ? r_cnt + 1'b1 : r_cnt;
        qneg  = (Q_W+1)'(r_q) > (Q_W+1)'(32768) ? (Q_W+1)'(32768) : (Q_W+1)'(r_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accum) begin
            if (dsum > (DOT_W+1)'((64'sd1 <<< (DOT_W-1)) - 1))
                r_dot <= {1'b0, {(DOT_W-1){1'b1}}};
            else if (dsum < -((DOT_W+1)'(64'sd1 <<< (DOT_W-1))))
                r_dot <= {1'b1, {(DOT_W-1){1'b0}}};
            else
                r_dot <= dsum[DOT_W-1:0];
            r_na  <= nsa[NORM_W] ? {NORM_W{1'b1}} : nsa[NORM_W-1:0];
            r_nb  <= nsb[NORM_W] ? {NORM_W{1'b1}} : nsb[NORM_W-1:0];
            r_cnt <= cnt_inc;
            if (cnt_inc > CNT_W'(MAX_LEN))
                r_ovf <= 1'b1;
        end else if (i_cmd.out_load) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_p) begin
            r_mc   <= PROD_W'(r_na);
            r_mp   <= MUL_W'(r_nb);
            r_prod <= '0;
        end else if (i_cmd.save_p) begin
            r_p    <= r_prod;
            r_mc   <= PROD_W'(mag);
            r_mp   <= mag;
            r_prod <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mp[0])
                r_prod <= r_prod + r_mc;
            r_mc <= r_mc << 1;
            r_mp <= r_mp >> 1;
        end
        if (i_cmd.save_l) begin
            r_l  <= r_prod;
            r_s  <= '0;
            r_ts <= '0;
            r_ps <= ROOT_W'({r_p, {LSH{1'b0}}});
            r_q  <= '0;
            r_k  <= 4'(Q_W - 1);
        end else if (i_cmd.root_step) begin
            if (trial <= lhs) begin
                r_s      <= trial;
                r_ts     <= (r_ts >> 1) + r_ps;
                r_q[r_k] <= 1'b1;
            end else begin
                r_ts <= r_ts >> 1;
            end
            r_ps <= r_ps >> 2;
            r_k  <= r_k - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.too_long  <= r_ovf;
            r_out.zero_norm <= o_sts.zero;
            if (o_sts.zero)
                r_out.similarity <= '0;
            else if (r_dot[DOT_W-1])
                r_out.similarity <= ELEM_W'(-qneg);
            else if (r_q > Q_W'(32767))
                r_out.similarity <= ELEM_W'(32767);
            else
                r_out.similarity <= r_q;
        end
    end

    assign o_sts.zero      = (r_na == '0) || (r_nb == '0);
    assign o_sts.root_last = (r_k == '0);
    assign o_out           = r_out;

endmodule

[rtl/cs_ctrl.sv]
module cs_ctrl import cs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_ACC, S_CHECK, S_MULP, S_SAVEP, S_MULL, S_SAVEL, S_ROOT, S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt;
    logic              r_out_valid;
    logic              load_ok;

    assign load_ok = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd           = '0;
        o_cmd.accum     = (r_state == S_ACC) && i_in_valid;
        o_cmd.load_p    = (r_state == S_CHECK) && !i_sts.zero;
        o_cmd.mul_step  = (r_state == S_MULP) || (r_state == S_MULL);
        o_cmd.save_p    = (r_state == S_SAVEP);
        o_cmd.save_l    = (r_state == S_SAVEL);
        o_cmd.root_step = (r_state == S_ROOT);
        o_cmd.out_load  = (r_state == S_FIN) && load_ok;
        n_state = r_state;
        unique case (r_state)
            S_ACC:   if (i_in_valid && i_in_last) n_state = S_CHECK;
            S_CHECK: n_state = i_sts.zero ? S_FIN : S_MULP;
            S_MULP:  if (r_cnt == STEP_W'(MUL_STEPS - 1)) n_state = S_SAVEP;
            S_SAVEP: n_state = S_MULL;
            S_MULL:  if (r_cnt == STEP_W'(MUL_STEPS - 1)) n_state = S_SAVEL;
            S_SAVEL: n_state = S_ROOT;
            S_ROOT:  if (i_sts.root_last) n_state = S_FIN;
            S_FIN:   if (load_ok) n_state = S_ACC;
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= o_cmd.mul_step && (n_state == r_state) ? r_cnt + 1'b1 : '0;
            if (o_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_ACC);
    assign o_out_valid = r_out_valid;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import cs_pkg::*;

    localparam int MAX_LEN    = MAX_LEN_D;
    localparam int LIMIT      = 2000000;
    localparam int HOLD_LEN   = 800;
    localparam logic signed [41:0] DOT_HI = {1'b0, {41{1'b1}}};
    localparam logic signed [41:0] DOT_LO = {1'b1, {41{1'b0}}};
    localparam logic [40:0] NORM_TOP = {41{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    cosine_similarity_q15 dut (.*);

    always #6 i_clk = ~i_clk;

    logic signed [41:0] dot_acc = '0;
    logic [40:0] norm_a_acc = '0;
    logic [40:0] norm_b_acc = '0;
    int unsigned pair_count = 0;
    bit too_long_seen = 0;
    t_out sim_expected[$];
    int errors = 0;
    int cycles = 0;
    bit hold_out = 0;
    bit quiet_out = 0;
    int hold_cycles = 0;

    function automatic logic [15:0] cos_q15(logic signed [41:0] dot, logic [40:0] na,
                                            logic [40:0] nb);
        logic [41:0] mag;
        logic [255:0] lhs, prod;
        int lo, hi, mid;
        mag = dot < 0 ? 42'(-dot) : 42'(dot);
        lhs = (256'(mag) << 15) * (256'(mag) << 15);
        prod = 256'(na) * 256'(nb);
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (prod * 256'(mid) * 256'(mid) <= lhs) lo = mid;
            else hi = mid - 1;
        end
        if (dot < 0) return 16'(-lo);
        return lo > 32767 ? 16'd32767 : 16'(lo);
    endfunction

    function automatic void cos_accumulate(t_in w);
        logic signed [63:0] a, b, d;
        logic [63:0] n;
        t_out r;
        a = w.element_a;
        b = w.element_b;
        d = 64'(dot_acc) + a * b;
        dot_acc = d > 64'(DOT_HI) ? DOT_HI : (d < 64'(DOT_LO) ? DOT_LO : 42'(d));
        n = 64'(norm_a_acc) + 64'(a * a);
        norm_a_acc = n > 64'(NORM_TOP) ? NORM_TOP : 41'(n);
        n = 64'(norm_b_acc) + 64'(b * b);
        norm_b_acc = n > 64'(NORM_TOP) ? NORM_TOP : 41'(n);
        if (pair_count <= MAX_LEN) pair_count++;
        if (pair_count > MAX_LEN) too_long_seen = 1;
        if (!w.last) return;
        r = '0;
        if (norm_a_acc == 0 || norm_b_acc == 0) begin
            r.zero_norm = 1'b1;
        end else begin
            r.similarity = cos_q15(dot_acc, norm_a_acc, norm_b_acc);
        end
        r.too_long = too_long_seen;
        sim_expected = {sim_expected, r};
        dot_acc = '0;
        norm_a_acc = '0;
        norm_b_acc = '0;
        pair_count = 0;
        too_long_seen = 0;
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
            : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
    endfunction

    task automatic send_word(logic signed [15:0] a, logic signed [15:0] b, logic last,
                             bit gaps = 1);
        int g;
        g = gaps ? short_gap() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{element_a: a, element_b: b, last: last};
        do @(posedge i_clk); while (o_in_stall);
        cos_accumulate('{element_a: a, element_b: b, last: last});
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sim_expected.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_word(16'sh7fff, 16'sh7fff, 1);
        send_word(16'sh8000, 16'sh8000, 1);
        send_word(16'sh8000, 16'sh7fff, 1);
        send_word(16'sh7fff, 16'sh8000, 1);
        send_word(0, 16'sh1234, 1);
        send_word(16'sh1234, 0, 1);
        send_word(0, 0, 1);
        send_word(16'sh4000, 16'sh0001, 0);
        send_word(16'sh0001, 16'sh4000, 1);
        send_word(16'sh5555, 16'shaaaa, 0);
        send_word(16'shffff, 16'sh0001, 1);
        send_word(16'sh0100, 16'sh0100, 0);
        send_word(16'sh0100, 16'sh0100, 0);
        send_word(16'sh0100, 16'sh0100, 1);
    endtask

    task automatic test_too_long();
        for (int i = 0; i < MAX_LEN; i++) send_word(16'sh8000, 16'sh8000, 0, 0);
        send_word(16'sh8000, 16'sh7fff, 1, 0);
        drain();
    endtask

    task automatic test_backpressure();
        hold_out = 1;
        fork
            for (int i = 0; i < 40; i++) send_word(rand_elem(), rand_elem(), i % 4 == 3);
            begin
                wait (hold_cycles >= HOLD_LEN);
                hold_out = 0;
            end
        join
        drain();
    endtask

    task automatic test_random();
        int len;
        int sent;
        sent = 0;
        while (sent < 800) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                send_word(rand_elem(), rand_elem(), i == len - 1);
                sent++;
            end
            if ($urandom_range(0, 30) == 0) quiet_out = ~quiet_out;
        end
        quiet_out = 0;
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_out) begin
            i_out_stall <= hold_out;
        end else if (quiet_out) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 39) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (hold_out) hold_cycles <= hold_cycles + 1;
        else hold_cycles <= 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sim_expected.size() == 0) begin
                $display("%0t: unexpected word %p", $time, o_out_data);
                errors++;
            end else begin
                want = sim_expected.pop_front();
                if (o_out_data.similarity !== want.similarity)
                    $display("%0t: similarity exp %0d got %0d", $time,
                             want.similarity, o_out_data.similarity);
                if (o_out_data.zero_norm !== want.zero_norm)
                    $display("%0t: zero_norm exp %b got %b", $time,
                             want.zero_norm, o_out_data.zero_norm);
                if (o_out_data.too_long !== want.too_long)
                    $display("%0t: too_long exp %b got %b", $time,
                             want.too_long, o_out_data.too_long);
                if (o_out_data !== want) errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain();
        test_backpressure();
        test_too_long();
        test_random();
        if (errors == 0 && sim_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cs_pkg.sv
rtl/cs_datapath.sv
rtl/cs_ctrl.sv
rtl/cosine_similarity_q15.sv
dv/testbench.sv
